>>> src/orf_pkg.sv
// Shared types and constants for the overwriting ring FIFO.
// Used by the controller, the datapath and the top level; depends on nothing.
package orf_pkg;

  // Default sizing of the storage.
  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed widths of the external word fields and of the capacity register.
  localparam int WORD_W    = 32;
  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;

  // Operation codes carried on op.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Status codes reported with every result word.
  localparam logic STS_OK   = 1'b0;
  localparam logic STS_FAIL = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // an input word is taken this cycle
    logic fetch_done;  // storage read data is valid this cycle
  } orf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic read_hit;    // the offered word is a read of a non-empty FIFO
  } orf_sts_t;

endpackage

>>> src/orf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module orf_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port with the data registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/orf_ctrl.sv
// Controller of the overwriting ring FIFO: input handshake, read wait state
// and the output valid flag. Depends on orf_pkg.
module orf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  orf_pkg::orf_sts_t sts,
  output orf_pkg::orf_cmd_t cmd
);
  import orf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic accept;

  // A word is taken when idle and the result register is free or emptying.
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign cmd.accept     = accept;
  assign cmd.fetch_done = (state == S_READ);

  // Next state and result valid flag.
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    case (state)
      S_IDLE: begin
        if (accept && sts.read_hit) begin
          state_next     = S_READ;
          out_valid_next = 1'b0;
        end else if (accept) begin
          out_valid_next = 1'b1;
        end else if (out_ready) begin
          out_valid_next = 1'b0;
        end
      end
      S_READ: begin
        state_next     = S_IDLE;
        out_valid_next = 1'b1;
      end
      default: begin
        state_next     = S_IDLE;
        out_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // The result register is empty while storage data is awaited.
  a_read_no_result: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !out_valid)
    else $error("result valid during the storage read");

  // A successful read presents its result in the cycle after the fetch.
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> out_valid && state == S_IDLE)
    else $error("read result not presented after the fetch");

  // No word is taken while a read is in flight.
  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !in_ready)
    else $error("input taken during a read");

endmodule

>>> src/orf_dp.sv
// Datapath of the overwriting ring FIFO: capacity register, pointers with
// wrap bits, storage RAM and result register. Depends on orf_pkg and orf_ram.
module orf_dp #(
  parameter int DEPTH      = orf_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = orf_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [orf_pkg::CAP_W-1:0]   cfg_wr_data,
  input  logic                        op,
  input  logic [orf_pkg::WORD_W-1:0]  write_data,
  input  orf_pkg::orf_cmd_t           cmd,
  output orf_pkg::orf_sts_t           sts,
  output logic                        status,
  output logic [orf_pkg::WORD_W-1:0]  read_data,
  output logic                        is_empty,
  output logic                        is_full
);
  import orf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (PTR_W > CAP_W) ? PTR_W : CAP_W;
  localparam int CAP_RESET_LIM = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
  localparam logic [CAP_W-1:0] CAP_LAST_RESET = CAP_W'(CAP_RESET_LIM - 1);
  localparam logic [CAP_W-1:0] CAP_LAST_MAX   = CAP_W'(DEPTH - 1);

  // Capacity is held as its last valid pointer value.
  logic [CAP_W-1:0]      cap_last;
  logic [CAP_W-1:0]      cap_last_next;
  logic [PTR_W-1:0]      rd_ptr;
  logic [PTR_W-1:0]      wr_ptr;
  logic                  rd_wrap;
  logic                  wr_wrap;
  logic [PTR_W-1:0]      rd_ptr_next;
  logic [PTR_W-1:0]      wr_ptr_next;
  logic                  rd_wrap_next;
  logic                  wr_wrap_next;
  logic                  empty;
  logic                  full;
  logic                  rd_last;
  logic                  wr_last;
  logic                  adv_rd;
  logic                  adv_wr;
  logic                  is_write;
  logic                  is_read;
  logic [DATA_WIDTH-1:0] ram_rd_data;

  assign empty = (rd_ptr == wr_ptr) && (rd_wrap == wr_wrap);
  assign full  = (rd_ptr == wr_ptr) && (rd_wrap != wr_wrap);

  assign is_write = cmd.accept && (op == OP_WRITE);
  assign is_read  = cmd.accept && (op == OP_READ);

  assign sts.read_hit = (op == OP_READ) && !empty;

  // A write into a full FIFO drops the oldest word first.
  assign adv_rd = (is_write && full) || (is_read && !empty);
  assign adv_wr = is_write;

  assign rd_last = (CMP_W'(rd_ptr) == CMP_W'(cap_last));
  assign wr_last = (CMP_W'(wr_ptr) == CMP_W'(cap_last));

  // Pointer increment with wrap at the capacity.
  always_comb begin
    rd_ptr_next  = rd_ptr;
    rd_wrap_next = rd_wrap;
    wr_ptr_next  = wr_ptr;
    wr_wrap_next = wr_wrap;
    if (adv_rd) begin
      if (rd_last) begin
        rd_ptr_next  = '0;
        rd_wrap_next = !rd_wrap;
      end else begin
        rd_ptr_next = rd_ptr + PTR_W'(1);
      end
    end
    if (adv_wr) begin
      if (wr_last) begin
        wr_ptr_next  = '0;
        wr_wrap_next = !wr_wrap;
      end else begin
        wr_ptr_next = wr_ptr + PTR_W'(1);
      end
    end
  end

  // A written capacity of zero acts as one, and one above DEPTH as DEPTH.
  always_comb begin
    if (cfg_wr_data == '0) begin
      cap_last_next = '0;
    end else if (int'(cfg_wr_data) > DEPTH) begin
      cap_last_next = CAP_LAST_MAX;
    end else begin
      cap_last_next = cfg_wr_data - CAP_W'(1);
    end
  end

  // Capacity and pointer registers; a capacity write empties the FIFO.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_last <= CAP_LAST_RESET;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      rd_wrap  <= 1'b0;
      wr_wrap  <= 1'b0;
    end else if (cfg_wr_en) begin
      cap_last <= cap_last_next;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      rd_wrap  <= 1'b0;
      wr_wrap  <= 1'b0;
    end else begin
      rd_ptr   <= rd_ptr_next;
      wr_ptr   <= wr_ptr_next;
      rd_wrap  <= rd_wrap_next;
      wr_wrap  <= wr_wrap_next;
    end
  end

  // Word storage.
  orf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (is_write),
    .wr_addr (wr_ptr),
    .wr_data (DATA_WIDTH'(write_data)),
    .rd_en   (is_read && !empty),
    .rd_addr (rd_ptr),
    .rd_data (ram_rd_data)
  );

  // Result register: flags at acceptance, read word once the storage answers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status    <= (is_read && empty) ? STS_FAIL : STS_OK;
      read_data <= '0;
      is_empty  <= (rd_ptr_next == wr_ptr_next) && (rd_wrap_next == wr_wrap_next);
      is_full   <= (rd_ptr_next == wr_ptr_next) && (rd_wrap_next != wr_wrap_next);
    end else if (cmd.fetch_done) begin
      read_data <= WORD_W'(ram_rd_data);
    end
  end

  // Pointers never pass the capacity in use.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(rd_ptr) <= CMP_W'(cap_last) && CMP_W'(wr_ptr) <= CMP_W'(cap_last))
    else $error("pointer beyond capacity");

  // After a write the FIFO holds at least one word.
  a_write_not_empty: assert property (@(posedge clk) disable iff (rst)
    is_write && !cfg_wr_en |=> !empty && !is_empty)
    else $error("FIFO empty after a write");

  // A read of an empty FIFO fails and leaves the pointers alone.
  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    is_read && empty && !cfg_wr_en |=> status == STS_FAIL && $stable(rd_ptr)
      && $stable(wr_ptr))
    else $error("read of an empty FIFO mishandled");

endmodule

>>> src/overwriting_ring_fifo.sv
// Overwriting ring FIFO: a write's result word is registered at acceptance;
// a read that succeeds waits in the read state for the storage RAM's registered
// read. Throughput: one write per cycle while the output is not stalled; a
// successful read holds off the input while its storage read is under way.
// Synchronous reset empties the FIFO and sets the capacity to 16 (or DEPTH if
// smaller); storage contents are not cleared. Depends on orf_pkg and modules.
module overwriting_ring_fifo #(
  parameter int DEPTH      = orf_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = orf_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [orf_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [orf_pkg::WORD_W-1:0] write_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       status,
  output logic [orf_pkg::WORD_W-1:0] read_data,
  output logic                       is_empty,
  output logic                       is_full
);
  import orf_pkg::*;

  orf_cmd_t cmd;
  orf_sts_t sts;

  // Handshake and sequencing.
  orf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Pointers, storage and result word.
  orf_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op          (op),
    .write_data  (write_data),
    .cmd         (cmd),
    .sts         (sts),
    .status      (status),
    .read_data   (read_data),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

endmodule
